FILE: rtl/core/atad_pkg.sv
// Shared types and constants of the ATA task file device.
// Holds register codes, status bits, command opcodes and request kinds.
// No dependencies.
package atad_pkg;

	// item operations (carried in s_tuser)
	localparam logic [1:0] OP_RD   = 2'd0;
	localparam logic [1:0] OP_WR   = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_FILL = 2'd3;

	// bus register indexes
	localparam logic [3:0] REG_DATA    = 4'd0;
	localparam logic [3:0] REG_ERROR   = 4'd1;
	localparam logic [3:0] REG_NSECT   = 4'd2;
	localparam logic [3:0] REG_SECT    = 4'd3;
	localparam logic [3:0] REG_LCYL    = 4'd4;
	localparam logic [3:0] REG_HCYL    = 4'd5;
	localparam logic [3:0] REG_SELECT  = 4'd6;
	localparam logic [3:0] REG_STATUS  = 4'd7;
	localparam logic [3:0] REG_CONTROL = 4'd14;

	// status, error and control bits
	localparam logic [7:0] ST_BUSY  = 8'h80;
	localparam logic [7:0] ST_READY = 8'h40;
	localparam logic [7:0] ST_SEEK  = 8'h10;
	localparam logic [7:0] ST_DRQ   = 8'h08;
	localparam logic [7:0] ST_ERR   = 8'h01;
	localparam logic [7:0] ER_ABORT = 8'h04;
	localparam int         CT_HOB_BIT  = 7;
	localparam int         CT_SRST_BIT = 2;
	localparam int         SEL_DEV_BIT = 4;

	// commands
	localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;
	localparam logic [7:0] CMD_RD         = 8'h20;
	localparam logic [7:0] CMD_RD_EXT     = 8'h24;
	localparam logic [7:0] CMD_RDMA       = 8'hC8;
	localparam logic [7:0] CMD_RDMA_EXT   = 8'h25;
	localparam logic [7:0] CMD_WR         = 8'h30;
	localparam logic [7:0] CMD_WR_EXT     = 8'h34;
	localparam logic [7:0] CMD_WDMA       = 8'hCA;
	localparam logic [7:0] CMD_WDMA_EXT   = 8'h35;
	localparam logic [7:0] CMD_NATMAX     = 8'hF8;
	localparam logic [7:0] CMD_NATMAX_EXT = 8'h27;
	localparam logic [7:0] CMD_SECURITY   = 8'h8E;
	localparam logic [7:0] SEC_FEATURE    = 8'hEC;

	// backing store request kinds
	localparam logic [1:0] REQ_READ     = 2'd0;
	localparam logic [1:0] REQ_COMMIT   = 2'd1;
	localparam logic [1:0] REQ_IDENTIFY = 2'd2;
	localparam logic [1:0] REQ_SECURITY = 2'd3;

	// configuration register indexes (byte address = 8 * index)
	localparam logic [1:0] CFG_PRESENT = 2'd0;
	localparam logic [1:0] CFG_SECTORS = 2'd1;
	localparam logic [1:0] CFG_TICKS   = 2'd2;

	localparam logic [47:0] LBA28_LIMIT    = 48'h0000_0FFF_FFFF;
	localparam logic [16:0] COUNT28_ZERO   = 17'h00100;
	localparam logic [16:0] COUNT48_ZERO   = 17'h10000;
	localparam logic [15:0] BUSY_TICKS_RST = 16'd1000;

	function automatic logic is_rd_cmd(input logic [7:0] c);
		return c == CMD_RD || c == CMD_RD_EXT || c == CMD_RDMA || c == CMD_RDMA_EXT;
	endfunction

	function automatic logic is_wr_cmd(input logic [7:0] c);
		return c == CMD_WR || c == CMD_WR_EXT || c == CMD_WDMA || c == CMD_WDMA_EXT;
	endfunction

endpackage

FILE: rtl/core/atad_buffer.sv
// Sector buffer: one synchronous memory with registered read data, plus
// per-word written marks so that a cleared buffer reads as zero.
// Depends on nothing outside this file.
module atad_buffer #(
	parameter int WORDS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] waddr,
	input  logic [15:0]              wdata,
	input  logic                     clr,
	input  logic                     re,
	input  logic [$clog2(WORDS)-1:0] raddr,
	output logic [15:0]              rdata
);

	logic [15:0]      mem [WORDS];
	logic [WORDS-1:0] mark_q;
	logic [15:0]      rd_q;
	logic             rd_mark_q;

	// storage write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// written marks: cleared when a buffer is opened
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q    <= '0;
			rd_mark_q <= 1'b0;
		end else begin
			if (clr) begin
				mark_q <= '0;
			end else if (we) begin
				mark_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_mark_q <= mark_q[raddr];
			end
		end
	end

	assign rdata = rd_mark_q ? rd_q : 16'h0000;

endmodule

FILE: rtl/core/ata_task_file_pio_device.sv
// ATA task file register block with PIO sector buffer and busy timer.
// Depends on atad_pkg and atad_buffer.
//
//  channel  | signals                        | content
//  s_*      | tvalid tready tdata tuser      | request: op, reg_index, wdata
//  m_*      | tvalid tready tdata tuser      | result: read data, irq, store req, word
//  apb      | psel penable pwrite paddr ...  | drive_present, disk_sectors, busy_ticks
//
// One request per cycle while s_tready is high; each result is registered and appears in the
// cycle after acceptance, with buffer data from the registered read port of the sector buffer.
// The result register holds while m_tready is low; s_tready is low only while
// a result waits and m_tready is low. Reset leaves no clearing pass: the buffer
// word marks are cleared at once.
module ata_task_file_pio_device #(
	parameter int BUFFER_WORDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // reg_index[3:0], wdata[19:4]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // rdata[15:0], irq_raise[16], irq_clear[17],
	                              // req_valid[18], req_lba[66:19], wr_valid[67],
	                              // wr_word[83:68], wr_index[91:84]
	output logic [1:0]  m_tuser,  // req_kind[1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(BUFFER_WORDS);
	localparam logic [AW:0] BLEN = (AW+1)'(BUFFER_WORDS);

	// configuration
	logic        present_q;
	logic [47:0] sectors_q;
	logic [15:0] ticks_q;

	// task file and control state
	logic [7:0]  feat_q, nsect_q, sect_q, lcyl_q, hcyl_q, sel_q;
	logic [7:0]  nsect_h_q, sect_h_q, lcyl_h_q, hcyl_h_q;
	logic [7:0]  status_q, error_q, ctrl_q, cmd_q;
	logic [AW:0] wp_q, blen_q;
	logic [AW-1:0] fp_q;
	logic [47:0] pend_addr_q;
	logic [16:0] pend_cnt_q;
	logic [15:0] busy_cnt_q;

	// next state
	logic [7:0]  n_feat, n_nsect, n_sect, n_lcyl, n_hcyl, n_sel;
	logic [7:0]  n_nsect_h, n_sect_h, n_lcyl_h, n_hcyl_h;
	logic [7:0]  n_status, n_error, n_ctrl, n_cmd;
	logic [AW:0] n_wp, n_blen;
	logic [AW-1:0] n_fp;
	logic [47:0] n_pend_addr;
	logic [16:0] n_pend_cnt;
	logic [15:0] n_busy_cnt;

	// result of the current request
	logic [15:0] r_rdata;
	logic        r_buf_rd, r_irq_raise, r_irq_clear, r_req_valid, r_wr_valid;
	logic [1:0]  r_req_kind;
	logic [47:0] r_req_lba;
	logic [15:0] r_wr_word;
	logic [7:0]  r_wr_index;

	// output register
	logic        ov_q;
	logic [15:0] rdata_s1;
	logic        buf_rd_s1, irq_raise_s1, irq_clear_s1, req_valid_s1, wr_valid_s1;
	logic [1:0]  req_kind_s1;
	logic [47:0] req_lba_s1;
	logic [15:0] wr_word_s1;
	logic [7:0]  wr_index_s1;

	// buffer port
	logic          buf_we, buf_clr, buf_re;
	logic [AW-1:0] buf_waddr;
	logic [15:0]   buf_rdata;

	logic        acc;
	logic [1:0]  op;
	logic [3:0]  idx;
	logic [15:0] wd;

	assign op       = s_tuser;
	assign idx      = s_tdata[3:0];
	assign wd       = s_tdata[19:4];
	assign s_tready = !ov_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	// configuration port
	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[4:3])
			atad_pkg::CFG_PRESENT: prdata = {63'd0, present_q};
			atad_pkg::CFG_SECTORS: prdata = {16'd0, sectors_q};
			atad_pkg::CFG_TICKS:   prdata = {48'd0, ticks_q};
			default:               prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			sectors_q <= 48'd0;
			ticks_q   <= atad_pkg::BUSY_TICKS_RST;
		end else if (cfg_we && paddr[2:0] == 3'd0) begin
			unique case (paddr[4:3])
				atad_pkg::CFG_PRESENT: present_q <= pwdata[0];
				atad_pkg::CFG_SECTORS: sectors_q <= pwdata[47:0];
				atad_pkg::CFG_TICKS:   ticks_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// request decode and task file update
	always_comb begin
		logic [7:0]  b;
		logic        hob, slave, do_data;
		logic [AW:0] wp_inc;
		logic [47:0] lba28, lba48, nat_v;
		logic [16:0] cnt28, cnt48, cnt_m1;

		b       = wd[7:0];
		hob     = ctrl_q[atad_pkg::CT_HOB_BIT];
		slave   = sel_q[atad_pkg::SEL_DEV_BIT];
		do_data = 1'b0;
		wp_inc  = wp_q + 1'b1;
		lba28   = {20'd0, sel_q[3:0], hcyl_q, lcyl_q, sect_q};
		lba48   = {hcyl_h_q, lcyl_h_q, sect_h_q, hcyl_q, lcyl_q, sect_q};
		cnt28   = (nsect_q == 8'd0) ? atad_pkg::COUNT28_ZERO : {9'd0, nsect_q};
		cnt48   = ({nsect_h_q, nsect_q} == 16'd0) ? atad_pkg::COUNT48_ZERO
			: {1'b0, nsect_h_q, nsect_q};
		cnt_m1  = pend_cnt_q - 17'd1;
		nat_v   = 48'd0;

		n_feat = feat_q; n_nsect = nsect_q; n_sect = sect_q; n_lcyl = lcyl_q;
		n_hcyl = hcyl_q; n_sel = sel_q; n_nsect_h = nsect_h_q; n_sect_h = sect_h_q;
		n_lcyl_h = lcyl_h_q; n_hcyl_h = hcyl_h_q; n_status = status_q;
		n_error = error_q; n_ctrl = ctrl_q; n_cmd = cmd_q; n_wp = wp_q;
		n_blen = blen_q; n_fp = fp_q; n_pend_addr = pend_addr_q;
		n_pend_cnt = pend_cnt_q; n_busy_cnt = busy_cnt_q;

		r_rdata = 16'd0; r_buf_rd = 1'b0; r_irq_raise = 1'b0; r_irq_clear = 1'b0;
		r_req_valid = 1'b0; r_req_kind = atad_pkg::REQ_READ; r_req_lba = 48'd0;
		r_wr_valid = 1'b0; r_wr_word = 16'd0; r_wr_index = 8'd0;

		buf_we = 1'b0; buf_waddr = fp_q; buf_clr = 1'b0; buf_re = 1'b0;

		unique case (op)
			atad_pkg::OP_RD: begin
				if (present_q && (!slave || idx == atad_pkg::REG_SELECT)) begin
					unique case (idx)
						atad_pkg::REG_DATA: begin
							if (wp_q < blen_q) begin
								r_buf_rd = 1'b1;
								buf_re   = 1'b1;
								do_data  = 1'b1;
							end
						end
						atad_pkg::REG_ERROR:   r_rdata = {8'd0, error_q};
						atad_pkg::REG_NSECT:   r_rdata = {8'd0, hob ? nsect_h_q : nsect_q};
						atad_pkg::REG_SECT:    r_rdata = {8'd0, hob ? sect_h_q : sect_q};
						atad_pkg::REG_LCYL:    r_rdata = {8'd0, hob ? lcyl_h_q : lcyl_q};
						atad_pkg::REG_HCYL:    r_rdata = {8'd0, hob ? hcyl_h_q : hcyl_q};
						atad_pkg::REG_SELECT:  r_rdata = {8'd0, sel_q};
						atad_pkg::REG_STATUS: begin
							r_rdata     = {8'd0, status_q};
							r_irq_clear = 1'b1;
						end
						atad_pkg::REG_CONTROL: r_rdata = {8'd0, status_q};
						default: ;
					endcase
				end
			end
			atad_pkg::OP_WR: begin
				if (present_q && (!slave || idx == atad_pkg::REG_SELECT
					|| idx == atad_pkg::REG_CONTROL)) begin
					unique case (idx)
						atad_pkg::REG_DATA: begin
							if (wp_q < blen_q) begin
								buf_we     = 1'b1;
								buf_waddr  = wp_q[AW-1:0];
								r_wr_valid = 1'b1;
								r_wr_word  = wd;
								r_wr_index = wp_q[7:0];
								do_data    = 1'b1;
							end
						end
						atad_pkg::REG_ERROR: n_feat = b;
						atad_pkg::REG_NSECT: begin n_nsect_h = nsect_q; n_nsect = b; end
						atad_pkg::REG_SECT:  begin n_sect_h = sect_q; n_sect = b; end
						atad_pkg::REG_LCYL:  begin n_lcyl_h = lcyl_q; n_lcyl = b; end
						atad_pkg::REG_HCYL:  begin n_hcyl_h = hcyl_q; n_hcyl = b; end
						atad_pkg::REG_SELECT: n_sel = b;
						atad_pkg::REG_STATUS: begin
							n_cmd      = b;
							n_status   = status_q | atad_pkg::ST_BUSY;
							n_busy_cnt = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
							// command start
							priority if (b == atad_pkg::CMD_IDENTIFY
								|| (b == atad_pkg::CMD_SECURITY
								&& feat_q == atad_pkg::SEC_FEATURE)) begin
								n_status    = n_status | atad_pkg::ST_DRQ;
								n_wp        = '0;
								n_blen      = BLEN;
								buf_clr     = 1'b1;
								r_req_valid = 1'b1;
								r_req_kind  = (b == atad_pkg::CMD_IDENTIFY)
									? atad_pkg::REQ_IDENTIFY : atad_pkg::REQ_SECURITY;
								n_fp        = '0;
							end else if (b == atad_pkg::CMD_SECURITY) begin
								n_error  = error_q | atad_pkg::ER_ABORT;
								n_status = n_status | atad_pkg::ST_ERR;
							end else if (atad_pkg::is_rd_cmd(b)) begin
								n_status    = n_status | atad_pkg::ST_DRQ;
								n_wp        = '0;
								n_blen      = BLEN;
								buf_clr     = 1'b1;
								r_req_valid = 1'b1;
								r_req_kind  = atad_pkg::REQ_READ;
								n_fp        = '0;
								if (b == atad_pkg::CMD_RD || b == atad_pkg::CMD_RDMA) begin
									r_req_lba  = lba28;
									n_pend_cnt = cnt28 - 17'd1;
								end else begin
									r_req_lba  = lba48;
									n_pend_cnt = cnt48 - 17'd1;
								end
								n_pend_addr = r_req_lba + 48'd1;
							end else if (atad_pkg::is_wr_cmd(b)) begin
								n_status = n_status | atad_pkg::ST_DRQ;
								n_wp     = '0;
								n_blen   = BLEN;
								buf_clr  = 1'b1;
								if (b == atad_pkg::CMD_WR || b == atad_pkg::CMD_WDMA) begin
									n_pend_addr = lba28;
									n_pend_cnt  = cnt28;
								end else begin
									n_pend_addr = lba48;
									n_pend_cnt  = cnt48;
								end
							end else if (b == atad_pkg::CMD_NATMAX) begin
								if (sectors_q > atad_pkg::LBA28_LIMIT) begin
									nat_v = atad_pkg::LBA28_LIMIT - 48'd1;
								end else begin
									nat_v = (sectors_q == 48'd0) ? 48'd0 : sectors_q - 48'd1;
								end
								n_sect = nat_v[7:0];
								n_lcyl = nat_v[15:8];
								n_hcyl = nat_v[23:16];
								n_sel  = {sel_q[7:4], nat_v[27:24]};
							end else if (b == atad_pkg::CMD_NATMAX_EXT) begin
								nat_v    = (sectors_q == 48'd0) ? 48'd0 : sectors_q - 48'd1;
								n_sect   = nat_v[7:0];
								n_lcyl   = nat_v[15:8];
								n_hcyl   = nat_v[23:16];
								n_sect_h = nat_v[31:24];
								n_lcyl_h = nat_v[39:32];
								n_hcyl_h = nat_v[47:40];
							end
						end
						atad_pkg::REG_CONTROL: begin
							n_ctrl = b;
							// software reset
							if (b[atad_pkg::CT_SRST_BIT]) begin
								n_status    = atad_pkg::ST_READY | atad_pkg::ST_SEEK;
								n_error     = 8'd1;
								n_sect      = 8'd1;
								n_nsect     = 8'd1;
								n_lcyl      = 8'd0;
								n_hcyl      = 8'd0;
								n_sect_h    = 8'd0;
								n_nsect_h   = 8'd0;
								n_lcyl_h    = 8'd0;
								n_hcyl_h    = 8'd0;
								n_wp        = '0;
								n_blen      = '0;
								n_pend_cnt  = 17'd0;
								n_pend_addr = 48'd0;
							end
						end
						default: ;
					endcase
				end
			end
			atad_pkg::OP_TICK: begin
				if (busy_cnt_q != 16'd0) begin
					n_busy_cnt = busy_cnt_q - 16'd1;
					if (busy_cnt_q == 16'd1) begin
						n_status    = status_q & ~atad_pkg::ST_BUSY;
						r_irq_raise = 1'b1;
					end
				end
			end
			default: begin
				// fill word from the backing store
				buf_we    = 1'b1;
				buf_waddr = fp_q;
				n_fp      = (fp_q == AW'(BUFFER_WORDS - 1)) ? '0 : fp_q + 1'b1;
			end
		endcase

		// data port advance and end of buffer
		if (do_data) begin
			n_wp = wp_inc;
			if (wp_inc >= blen_q) begin
				priority if (cmd_q == atad_pkg::CMD_IDENTIFY
					|| cmd_q == atad_pkg::CMD_SECURITY) begin
					n_status = status_q & ~atad_pkg::ST_DRQ;
				end else if (atad_pkg::is_wr_cmd(cmd_q)) begin
					r_req_valid = 1'b1;
					r_req_kind  = atad_pkg::REQ_COMMIT;
					r_req_lba   = pend_addr_q;
					n_pend_addr = pend_addr_q + 48'd1;
					n_pend_cnt  = cnt_m1;
					if (cnt_m1 == 17'd0) begin
						n_status = status_q & ~atad_pkg::ST_DRQ;
					end else begin
						n_wp   = '0;
						n_blen = BLEN;
					end
				end else if (atad_pkg::is_rd_cmd(cmd_q)) begin
					if (pend_cnt_q == 17'd0) begin
						n_status = status_q & ~atad_pkg::ST_DRQ;
					end else begin
						r_req_valid = 1'b1;
						r_req_kind  = atad_pkg::REQ_READ;
						r_req_lba   = pend_addr_q;
						n_fp        = '0;
						n_pend_addr = pend_addr_q + 48'd1;
						n_wp        = '0;
						n_blen      = BLEN;
						n_pend_cnt  = cnt_m1;
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_q <= 8'd0; nsect_q <= 8'd1; sect_q <= 8'd1; lcyl_q <= 8'd0;
			hcyl_q <= 8'd0; sel_q <= 8'd0; nsect_h_q <= 8'd0; sect_h_q <= 8'd0;
			lcyl_h_q <= 8'd0; hcyl_h_q <= 8'd0;
			status_q <= atad_pkg::ST_READY | atad_pkg::ST_SEEK;
			error_q <= 8'd0; ctrl_q <= 8'd0; cmd_q <= 8'd0;
			wp_q <= '0; blen_q <= '0; fp_q <= '0;
			pend_addr_q <= 48'd0; pend_cnt_q <= 17'd0; busy_cnt_q <= 16'd0;
		end else if (acc) begin
			feat_q <= n_feat; nsect_q <= n_nsect; sect_q <= n_sect; lcyl_q <= n_lcyl;
			hcyl_q <= n_hcyl; sel_q <= n_sel; nsect_h_q <= n_nsect_h;
			sect_h_q <= n_sect_h; lcyl_h_q <= n_lcyl_h; hcyl_h_q <= n_hcyl_h;
			status_q <= n_status; error_q <= n_error; ctrl_q <= n_ctrl; cmd_q <= n_cmd;
			wp_q <= n_wp; blen_q <= n_blen; fp_q <= n_fp;
			pend_addr_q <= n_pend_addr; pend_cnt_q <= n_pend_cnt;
			busy_cnt_q <= n_busy_cnt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (acc) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1     <= r_rdata;
			buf_rd_s1    <= r_buf_rd;
			irq_raise_s1 <= r_irq_raise;
			irq_clear_s1 <= r_irq_clear;
			req_valid_s1 <= r_req_valid;
			req_kind_s1  <= r_req_kind;
			req_lba_s1   <= r_req_lba;
			wr_valid_s1  <= r_wr_valid;
			wr_word_s1   <= r_wr_word;
			wr_index_s1  <= r_wr_index;
		end
	end

	atad_buffer #(
		.WORDS(BUFFER_WORDS)
	) u_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (acc && buf_we),
		.waddr (buf_waddr),
		.wdata (wd),
		.clr   (acc && buf_clr),
		.re    (acc && buf_re),
		.raddr (wp_q[AW-1:0]),
		.rdata (buf_rdata)
	);

	assign m_tvalid = ov_q;
	assign m_tuser  = req_kind_s1;
	assign m_tdata  = {4'd0, wr_index_s1, wr_word_s1, wr_valid_s1, req_lba_s1,
		req_valid_s1, irq_clear_s1, irq_raise_s1, buf_rd_s1 ? buf_rdata : rdata_s1};

	// checks
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= blen_q) else $error("word pointer past buffer length");
	a_irq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && irq_raise_s1 |-> busy_cnt_q == 16'd0)
		else $error("interrupt raised with busy count running");
	a_req_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !req_valid_s1 |-> req_lba_s1 == 48'd0 && req_kind_s1 == atad_pkg::REQ_READ)
		else $error("request fields set without request");
	a_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !wr_valid_s1 |-> wr_word_s1 == 16'd0 && wr_index_s1 == 8'd0)
		else $error("write word set without write");
	a_busy_drq: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == atad_pkg::OP_WR && idx == atad_pkg::REG_STATUS && present_q
		&& !sel_q[atad_pkg::SEL_DEV_BIT] |=> busy_cnt_q != 16'd0)
		else $error("command did not start busy count");

endmodule
